### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_CLK(lbl, !(cond))

`else

`define ASSERT_CLK(lbl, prop)

`define ASSERT_NEVER(lbl, cond)

`endif

`endif

### design/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg
// shared types and constants of the differential drive mixer
// ----------------------------------------------------------------------------
package ddm_pkg;

  localparam int FRAC_BITS      = 12;
  localparam int POLL_PERIOD_MS = 25;
  localparam int QDEPTH         = 4;
  localparam int QAW            = $clog2(QDEPTH);
  localparam int QCW            = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic [2:0] REG_LINEAR_LIMIT  = 3'd0;
  localparam logic [2:0] REG_ANGULAR_LIMIT = 3'd1;
  localparam logic [2:0] REG_SCALE_FACTOR  = 3'd2;
  localparam logic [2:0] REG_TRACK_WIDTH   = 3'd3;
  localparam logic [2:0] REG_WHEEL_LIMIT   = 3'd4;
  localparam logic [2:0] REG_TURN_BOOST    = 3'd5;
  localparam logic [2:0] REG_TIMEOUT_MS    = 3'd6;
  localparam logic [2:0] REG_MIN_GAP_MS    = 3'd7;

  localparam logic [14:0] RST_LINEAR_LIMIT  = 15'd4096;
  localparam logic [14:0] RST_ANGULAR_LIMIT = 15'd4096;
  localparam logic [14:0] RST_SCALE_FACTOR  = 15'd4096;
  localparam logic [14:0] RST_TRACK_WIDTH   = 15'd819;
  localparam logic [14:0] RST_WHEEL_LIMIT   = 15'd4096;
  localparam logic [14:0] RST_TURN_BOOST    = 15'd0;
  localparam logic [15:0] RST_TIMEOUT_MS    = 16'd500;
  localparam logic [15:0] RST_MIN_GAP_MS    = 16'd0;

  typedef enum logic [1:0] {
    OP_CMD,
    OP_TICK,
    OP_STOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] lin;
    logic signed [15:0] ang;
  } qent_t;

  typedef struct packed {
    logic [14:0] linear_limit;
    logic [14:0] angular_limit;
    logic [14:0] scale_factor;
    logic [14:0] track_width;
    logic [14:0] wheel_limit;
    logic [14:0] turn_boost;
    logic [15:0] timeout_ms;
    logic [15:0] min_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic               published;
    logic               sent;
    logic signed [15:0] exec_linear;
    logic signed [15:0] exec_angular;
    logic signed [15:0] left_wheel;
    logic signed [15:0] right_wheel;
    logic               moving;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MX,
    ST_MZ,
    ST_MH,
    ST_FIN
  } back_st_t;

endpackage

### design/ddm_queue.sv
// ----------------------------------------------------------------------------
// ddm_queue
// short word queue between the classifier and the execution unit
// ----------------------------------------------------------------------------
module ddm_queue
  import ddm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr,
  input  qent_t wdata,
  input  logic  rd,
  output qent_t rdata,
  output logic  full,
  output logic  empty
);

  qent_t          mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign full  = (cnt_r == QCW'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? QAW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = do_rd ? QAW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = QCW'(cnt_r + 1'b1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = QCW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

### design/ddm_front.sv
// ----------------------------------------------------------------------------
// ddm_front
// accepts commands and ticks, runs the command timer and watchdog poll
// ----------------------------------------------------------------------------
module ddm_front
  import ddm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               kind,
  input  logic signed [15:0] linear_in,
  input  logic signed [15:0] angular_in,
  input  logic               q_full,
  input  logic [15:0]        timeout_ms,
  output logic               q_wr,
  output qent_t              q_wdata
);

  logic [15:0] cmd_ms_r, cmd_ms_nxt;
  logic [4:0]  poll_r, poll_nxt;
  logic [4:0]  poll_inc;
  logic [15:0] cmd_ms_inc;

  assign q_wr       = push && !q_full;
  assign poll_inc   = 5'(poll_r + 1'b1);
  assign cmd_ms_inc = (cmd_ms_r == 16'hFFFF) ? cmd_ms_r : 16'(cmd_ms_r + 1'b1);

  always_comb begin
    cmd_ms_nxt    = cmd_ms_r;
    poll_nxt      = poll_r;
    q_wdata.op    = OP_CMD;
    q_wdata.lin   = linear_in;
    q_wdata.ang   = angular_in;
    if (kind) begin
      cmd_ms_nxt  = cmd_ms_inc;
      poll_nxt    = poll_inc;
      q_wdata.op  = OP_TICK;
      q_wdata.lin = '0;
      q_wdata.ang = '0;
      if (poll_inc >= 5'(POLL_PERIOD_MS)) begin
        poll_nxt = '0;
        if (cmd_ms_inc > timeout_ms) begin
          q_wdata.op = OP_STOP;
        end
      end
    end else begin
      cmd_ms_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_ms_r <= '0;
      poll_r   <= '0;
    end else if (q_wr) begin
      cmd_ms_r <= cmd_ms_nxt;
      poll_r   <= poll_nxt;
    end
  end

endmodule

### design/ddm_back.sv
// ----------------------------------------------------------------------------
// ddm_back
// executes queued words on one shared multiplier and holds the result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddm_back
  import ddm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_empty,
  input  qent_t q_data,
  output logic  q_rd,
  input  logic  pop,
  output logic  empty,
  output res_t  res
);

  localparam int MW = 32 - FRAC_BITS;
  localparam int HW = 31 - FRAC_BITS;
  localparam logic signed [15:0] DEADBAND = 16'((1 << FRAC_BITS) / 1000);

  function automatic logic signed [15:0] clamp_in(logic signed [15:0] v, logic [14:0] lim);
    logic signed [15:0] l;
    l = $signed({1'b0, lim});
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function automatic logic signed [15:0] sat_mw(logic signed [MW-1:0] v);
    if (v > MW'(32767)) return 16'sh7FFF;
    if (v < -MW'(32768)) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] clamp_mw(logic signed [MW-1:0] v, logic [14:0] lim);
    logic signed [MW-1:0] l;
    l = $signed({{(MW-15){1'b0}}, lim});
    if (v > l) return 16'(l);
    if (v < -l) return 16'(-l);
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] boost(logic signed [15:0] w, logic [14:0] b);
    logic signed [MW-1:0] wx, bx;
    wx = {{(MW-16){w[15]}}, w};
    bx = $signed({{(MW-15){1'b0}}, b});
    return sat_mw(w[15] ? MW'(wx - bx) : MW'(wx + bx));
  endfunction

  back_st_t           st_r, st_nxt;
  op_t                op_r, op_nxt;
  logic signed [15:0] lin_r, lin_nxt, ang_r, ang_nxt;
  logic signed [15:0] x_r, x_nxt, z_r, z_nxt;
  logic signed [31:0] prod_r, prod_nxt, prod_c;
  logic signed [15:0] mul_a, mul_b;
  logic [15:0]        send_ms_r, send_ms_nxt, send_inc;
  logic               moving_r, moving_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               res_r, res_nxt;
  logic               wr_res, out_free, out_pop;
  logic signed [15:0] scl_c;
  logic signed [MW-1:0] xw, half;
  logic signed [15:0] l0, r0;
  logic               xnz, znz, send_ok;

  assign out_pop  = pop && out_valid_r;
  assign out_free = !out_valid_r || out_pop;
  assign empty    = !out_valid_r;
  assign res      = res_r;

  assign prod_c   = mul_a * mul_b;
  assign scl_c    = sat_mw(prod_r[31:FRAC_BITS]);
  assign send_inc = (send_ms_r == 16'hFFFF) ? send_ms_r : 16'(send_ms_r + 1'b1);
  assign xw       = {{(MW-16){x_r[15]}}, x_r};
  assign half     = {{(MW-HW){prod_r[31]}}, prod_r[31:FRAC_BITS+1]};
  assign l0       = clamp_mw(MW'(xw - half), cfg.wheel_limit);
  assign r0       = clamp_mw(MW'(xw + half), cfg.wheel_limit);
  assign xnz      = (x_r > DEADBAND) || (x_r < -DEADBAND);
  assign znz      = (z_r > DEADBAND) || (z_r < -DEADBAND);
  assign send_ok  = (send_ms_r >= cfg.min_gap_ms);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty && q_data.op != OP_TICK) st_nxt = ST_MX;
      end
      ST_MX:   st_nxt = ST_MZ;
      ST_MZ:   st_nxt = ST_MH;
      ST_MH:   st_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_rd        = 1'b0;
    wr_res      = 1'b0;
    op_nxt      = op_r;
    lin_nxt     = lin_r;
    ang_nxt     = ang_r;
    x_nxt       = x_r;
    z_nxt       = z_r;
    prod_nxt    = prod_r;
    send_ms_nxt = send_ms_r;
    moving_nxt  = moving_r;
    res_nxt     = res_r;
    mul_a       = '0;
    mul_b       = '0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_data.op == OP_TICK) begin
            if (out_free) begin
              q_rd        = 1'b1;
              wr_res      = 1'b1;
              send_ms_nxt = send_inc;
              res_nxt     = '0;
              res_nxt.moving = moving_r;
            end
          end else begin
            q_rd    = 1'b1;
            op_nxt  = q_data.op;
            lin_nxt = q_data.lin;
            ang_nxt = q_data.ang;
            if (q_data.op == OP_STOP) send_ms_nxt = send_inc;
          end
        end
      end
      ST_MX: begin
        mul_a    = clamp_in(lin_r, cfg.linear_limit);
        mul_b    = $signed({1'b0, cfg.scale_factor});
        prod_nxt = prod_c;
      end
      ST_MZ: begin
        x_nxt    = scl_c;
        mul_a    = clamp_in(ang_r, cfg.angular_limit);
        mul_b    = $signed({1'b0, cfg.scale_factor});
        prod_nxt = prod_c;
      end
      ST_MH: begin
        z_nxt    = scl_c;
        mul_a    = scl_c;
        mul_b    = $signed({1'b0, cfg.track_width});
        prod_nxt = prod_c;
      end
      ST_FIN: begin
        if (out_free) begin
          wr_res               = 1'b1;
          moving_nxt           = (op_r == OP_STOP) ? 1'b0 : (xnz || znz);
          res_nxt.published    = 1'b1;
          res_nxt.sent         = send_ok;
          res_nxt.exec_linear  = x_r;
          res_nxt.exec_angular = z_r;
          res_nxt.moving       = moving_nxt;
          res_nxt.left_wheel   = '0;
          res_nxt.right_wheel  = '0;
          if (send_ok) begin
            send_ms_nxt = '0;
            if (!xnz && znz) begin
              res_nxt.left_wheel  = boost(l0, cfg.turn_boost);
              res_nxt.right_wheel = boost(r0, cfg.turn_boost);
            end else begin
              res_nxt.left_wheel  = l0;
              res_nxt.right_wheel = r0;
            end
          end
        end
      end
      default: begin
        q_rd = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (wr_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      op_r        <= OP_CMD;
      send_ms_r   <= 16'hFFFF;
      moving_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      op_r        <= op_nxt;
      send_ms_r   <= send_ms_nxt;
      moving_r    <= moving_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lin_r  <= lin_nxt;
    ang_r  <= ang_nxt;
    x_r    <= x_nxt;
    z_r    <= z_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  `ASSERT_CLK(a_res_kept, out_valid_r && !pop |=> out_valid_r && $stable(res_r))
  `ASSERT_CLK(a_sent_pub, out_valid_r && res_r.sent |-> res_r.published)
  `ASSERT_CLK(a_send_clear, wr_res && res_nxt.sent |=> send_ms_r == 16'd0)
  `ASSERT_NEVER(a_no_tick_busy, st_r != ST_IDLE && op_r == OP_TICK)
  `ASSERT_CLK(a_quiet_zero, out_valid_r && !res_r.published |-> res_r.left_wheel == 16'sd0)

endmodule

### design/diff_drive_mixer_with_watchdog.sv
// ----------------------------------------------------------------------------
// diff_drive_mixer_with_watchdog
// twist to wheel speed mixer with rate limit and command watchdog
// ----------------------------------------------------------------------------
// input side: a word is taken when push is high and full is low. kind 0 is a
// velocity command (linear_in, angular_in, Q4.12), kind 1 a 1 ms tick.
// result side: every word gives one result; it sits on the out_ ports while
// empty is low and leaves when pop is high. a stalled receiver keeps the
// result; up to five more words wait inside (four in the internal queue, one
// in the execution unit), then full rises.
// cfg side: cfg_ready is always high; cfg_index selects one of eight limits
// and timers; the user must write them only while no word is in flight, as
// the block does not enforce it. timing: a tick result is written as the
// tick leaves the queue; a command passes the states MX, MZ, MH and FIN of
// the execution unit, as its three products (two scalings and mix term) go
// through one multiplier; ticks drain at one per cycle while pop keeps up.
// reset: synchronous, active low; empties queue and result register, clears
// the timers (time since last send reads as saturated) and the moving flag,
// and loads the default limits.
// ----------------------------------------------------------------------------
module diff_drive_mixer_with_watchdog
  import ddm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_kind,
  input  logic signed [15:0] in_linear_in,
  input  logic signed [15:0] in_angular_in,
  output logic               empty,
  input  logic               pop,
  output logic               out_published,
  output logic               out_sent,
  output logic signed [15:0] out_exec_linear,
  output logic signed [15:0] out_exec_angular,
  output logic signed [15:0] out_left_wheel,
  output logic signed [15:0] out_right_wheel,
  output logic               out_moving,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t  cfg_r, cfg_nxt;
  qent_t q_wdata, q_rdata;
  logic  q_wr, q_rd, q_empty;
  res_t  res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_LINEAR_LIMIT:  cfg_nxt.linear_limit  = cfg_data[14:0];
        REG_ANGULAR_LIMIT: cfg_nxt.angular_limit = cfg_data[14:0];
        REG_SCALE_FACTOR:  cfg_nxt.scale_factor  = cfg_data[14:0];
        REG_TRACK_WIDTH:   cfg_nxt.track_width   = cfg_data[14:0];
        REG_WHEEL_LIMIT:   cfg_nxt.wheel_limit   = cfg_data[14:0];
        REG_TURN_BOOST:    cfg_nxt.turn_boost    = cfg_data[14:0];
        REG_TIMEOUT_MS:    cfg_nxt.timeout_ms    = cfg_data;
        REG_MIN_GAP_MS:    cfg_nxt.min_gap_ms    = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.linear_limit  <= RST_LINEAR_LIMIT;
      cfg_r.angular_limit <= RST_ANGULAR_LIMIT;
      cfg_r.scale_factor  <= RST_SCALE_FACTOR;
      cfg_r.track_width   <= RST_TRACK_WIDTH;
      cfg_r.wheel_limit   <= RST_WHEEL_LIMIT;
      cfg_r.turn_boost    <= RST_TURN_BOOST;
      cfg_r.timeout_ms    <= RST_TIMEOUT_MS;
      cfg_r.min_gap_ms    <= RST_MIN_GAP_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ddm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .kind       (in_kind),
    .linear_in  (in_linear_in),
    .angular_in (in_angular_in),
    .q_full     (full),
    .timeout_ms (cfg_r.timeout_ms),
    .q_wr       (q_wr),
    .q_wdata    (q_wdata)
  );

  ddm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (full),
    .empty (q_empty)
  );

  ddm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_published    = res.published;
  assign out_sent         = res.sent;
  assign out_exec_linear  = res.exec_linear;
  assign out_exec_angular = res.exec_angular;
  assign out_left_wheel   = res.left_wheel;
  assign out_right_wheel  = res.right_wheel;
  assign out_moving       = res.moving;

endmodule
